[src/frlpm_pkg.sv]
// Shared types and constants of the flash ring log pointer manager.
`timescale 1ns / 1ps
package frlpm_pkg;

   // Widths of the fixed fields at the ports
   localparam int FIELD_W = 24;
   localparam int LIMIT_W = 25;
   localparam int CSR_W   = 25;
   localparam int FUNC_W  = 2;
   localparam int CSR_IDX_W = 1;

   // Flash sector size; a power of two so the sector index is a shift
   localparam int SECTOR_BYTES = 4096;

   // Register reset values
   localparam logic [FIELD_W-1:0] LOG_BASE_RST  = 24'h102000;
   localparam logic [LIMIT_W-1:0] LOG_LIMIT_RST = 25'h1000000;

   // Register indexes on the write port
   localparam logic [CSR_IDX_W-1:0] CSR_LOG_BASE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOG_LIMIT = 1'b1;

   // Request function codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_PREPARE  = 2'd0,
      FUNC_OUTCOME  = 2'd1,
      FUNC_SET_READ = 2'd2
   } func_type;

   // Sequencer states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic rsp_free;
   } stat_type;

endpackage

[src/flash_ring_log_pointer_manager_core.sv]
// A request is captured in the request register, then the sequencer executes
// it into the response register. A new request is taken only once the last
// one has executed, also while its response waits; its execute step then
// stalls until the response register is free.
// Reset (synchronous) sets both pointers to the log_base reset value, clears
// the full flag and the erased-sector mark, and restores register defaults.
`timescale 1ns / 1ps
module flash_ring_log_pointer_manager_core #(
   parameter int RECORD_BYTES = 256,
   parameter int ADDR_BITS    = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [frlpm_pkg::FUNC_W-1:0]    req_func,
   input  logic                            req_write_ok,
   input  logic [frlpm_pkg::FIELD_W-1:0]   req_new_read_addr,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [frlpm_pkg::FIELD_W-1:0]   rsp_write_addr,
   output logic                            rsp_erase_now,
   output logic [frlpm_pkg::FIELD_W-1:0]   rsp_erase_addr,
   output logic                            rsp_dropped_oldest,
   output logic [frlpm_pkg::FIELD_W-1:0]   rsp_read_addr,
   output logic                            rsp_log_full,
   output logic                            rsp_data_ready,
   input  logic                            csr_we,
   input  logic [frlpm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [frlpm_pkg::CSR_W-1:0]     csr_wdata
);
   import frlpm_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequencer
   frlpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath
   frlpm_datapath #(
      .RECORD_BYTES (RECORD_BYTES),
      .ADDR_BITS    (ADDR_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_func           (req_func),
      .req_write_ok       (req_write_ok),
      .req_new_read_addr  (req_new_read_addr),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_write_addr     (rsp_write_addr),
      .rsp_erase_now      (rsp_erase_now),
      .rsp_erase_addr     (rsp_erase_addr),
      .rsp_dropped_oldest (rsp_dropped_oldest),
      .rsp_read_addr      (rsp_read_addr),
      .rsp_log_full       (rsp_log_full),
      .rsp_data_ready     (rsp_data_ready)
   );

endmodule

[src/frlpm_ctrl.sv]
// Request sequencer: captures a request, then executes it into the response register.
`timescale 1ns / 1ps
module frlpm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  frlpm_pkg::stat_type stat,
   output frlpm_pkg::cmd_type  cmd
);
   import frlpm_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // nothing is taken while reset is held
            if (!reset) begin
               req_ready = 1'b1;
               if (req_valid) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            // wait until the response slot can take the result
            if (stat.rsp_free) begin
               cmd.execute = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[src/frlpm_datapath.sv]
// Pointer datapath: config registers, pointer state, update logic and response register.
`timescale 1ns / 1ps
module frlpm_datapath #(
   parameter int RECORD_BYTES = 256,
   parameter int ADDR_BITS    = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  frlpm_pkg::cmd_type                  cmd,
   output frlpm_pkg::stat_type                 stat,
   input  logic [frlpm_pkg::FUNC_W-1:0]        req_func,
   input  logic                                req_write_ok,
   input  logic [frlpm_pkg::FIELD_W-1:0]       req_new_read_addr,
   input  logic                                csr_we,
   input  logic [frlpm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [frlpm_pkg::CSR_W-1:0]         csr_wdata,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [frlpm_pkg::FIELD_W-1:0]       rsp_write_addr,
   output logic                                rsp_erase_now,
   output logic [frlpm_pkg::FIELD_W-1:0]       rsp_erase_addr,
   output logic                                rsp_dropped_oldest,
   output logic [frlpm_pkg::FIELD_W-1:0]       rsp_read_addr,
   output logic                                rsp_log_full,
   output logic                                rsp_data_ready
);
   import frlpm_pkg::*;

   localparam int AW    = ADDR_BITS;
   // compare width: wide enough for pointer plus record and for the limit
   localparam int CW    = (AW + 1 > LIMIT_W) ? AW + 1 : LIMIT_W;
   localparam int SHIFT = $clog2(SECTOR_BYTES);
   localparam int SW    = (AW > SHIFT) ? AW - SHIFT : 1;

   // Config registers
   logic [FIELD_W-1:0] log_base_ff;
   logic [LIMIT_W-1:0] log_limit_ff;

   // Captured request
   logic [FUNC_W-1:0]  func_ff;
   logic               write_ok_ff;
   logic [FIELD_W-1:0] new_read_ff;

   // Pointer state
   logic [AW-1:0] wp_ff, wp_in;
   logic [AW-1:0] rp_ff, rp_in;
   logic          wrapped_ff, wrapped_in;
   logic [SW-1:0] erased_sector_ff, erased_sector_in;
   logic          erased_valid_ff, erased_valid_in;

   // Response register
   logic               rsp_valid_ff;
   logic [FIELD_W-1:0] rsp_write_addr_ff;
   logic               rsp_erase_now_ff, rsp_erase_now_in;
   logic [FIELD_W-1:0] rsp_erase_addr_ff, rsp_erase_addr_in;
   logic               rsp_dropped_ff, rsp_dropped_in;
   logic [FIELD_W-1:0] rsp_read_addr_ff;
   logic               rsp_log_full_ff;
   logic               rsp_data_ready_ff, rsp_data_ready_in;

   // Address arithmetic
   logic [AW-1:0] base_a;
   logic [CW-1:0] base_c, limit_c, rec_c;
   logic [CW-1:0] wp_sum, wp_next_c, rp_sum;
   logic          wp_wrap, rp_wrap, drop_cond, erase_need;
   logic [AW-1:0] rp_adv;
   logic [SW-1:0] sector_w;
   logic [AW-1:0] sector_base;

   assign base_a  = AW'(log_base_ff);
   assign base_c  = CW'(base_a);
   assign limit_c = CW'(log_limit_ff);
   assign rec_c   = CW'(RECORD_BYTES);

   // next write address, wrapping at the limit
   assign wp_sum    = CW'(wp_ff) + rec_c;
   assign wp_wrap   = (wp_sum >= limit_c);
   assign wp_next_c = wp_wrap ? base_c : wp_sum;

   // read pointer one record on, wrapping at the limit
   assign rp_sum  = CW'(rp_ff) + rec_c;
   assign rp_wrap = (rp_sum >= limit_c);
   assign rp_adv  = rp_wrap ? base_a : rp_sum[AW-1:0];

   // the next record would land on the oldest one
   assign drop_cond = wrapped_ff &&
                      (((wp_ff < rp_ff) && (wp_next_c >= CW'(rp_ff))) ||
                       (wp_wrap && (rp_ff <= wp_ff)));

   // sector of the write pointer against the last erased one
   assign sector_w    = SW'(wp_ff >> SHIFT);
   assign sector_base = (wp_ff >> SHIFT) << SHIFT;
   assign erase_need  = !erased_valid_ff || (sector_w != erased_sector_ff);

   // Request execution
   always_comb begin
      wp_in             = wp_ff;
      rp_in             = rp_ff;
      wrapped_in        = wrapped_ff;
      erased_sector_in  = erased_sector_ff;
      erased_valid_in   = erased_valid_ff;
      rsp_erase_now_in  = 1'b0;
      rsp_erase_addr_in = '0;
      rsp_dropped_in    = 1'b0;
      rsp_data_ready_in = 1'b0;
      unique case (func_ff)
         FUNC_PREPARE: begin
            if (drop_cond) begin
               rp_in          = rp_adv;
               rsp_dropped_in = 1'b1;
            end
            if (erase_need) begin
               rsp_erase_now_in  = 1'b1;
               rsp_erase_addr_in = FIELD_W'(sector_base);
               erased_sector_in  = sector_w;
               erased_valid_in   = 1'b1;
            end
         end
         FUNC_OUTCOME: begin
            if (write_ok_ff) begin
               wp_in             = wp_next_c[AW-1:0];
               rsp_data_ready_in = 1'b1;
               if (wp_wrap) begin
                  wrapped_in = 1'b1;
               end
            end
         end
         FUNC_SET_READ: begin
            rp_in = AW'(new_read_ff);
         end
         default: begin
            // unused code: report state, change nothing
         end
      endcase
   end

   // Config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         log_base_ff  <= LOG_BASE_RST;
         log_limit_ff <= LOG_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOG_BASE:  log_base_ff  <= csr_wdata[FIELD_W-1:0];
            CSR_LOG_LIMIT: log_limit_ff <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff     <= req_func;
         write_ok_ff <= req_write_ok;
         new_read_ff <= req_new_read_addr;
      end
   end

   // Pointer state
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff            <= AW'(LOG_BASE_RST);
         rp_ff            <= AW'(LOG_BASE_RST);
         wrapped_ff       <= 1'b0;
         erased_sector_ff <= '0;
         erased_valid_ff  <= 1'b0;
      end else if (cmd.execute) begin
         wp_ff            <= wp_in;
         rp_ff            <= rp_in;
         wrapped_ff       <= wrapped_in;
         erased_sector_ff <= erased_sector_in;
         erased_valid_ff  <= erased_valid_in;
      end
   end

   // Response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.execute) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_write_addr_ff <= FIELD_W'(wp_in);
         rsp_erase_now_ff  <= rsp_erase_now_in;
         rsp_erase_addr_ff <= rsp_erase_addr_in;
         rsp_dropped_ff    <= rsp_dropped_in;
         rsp_read_addr_ff  <= FIELD_W'(rp_in);
         rsp_log_full_ff   <= wrapped_in;
         rsp_data_ready_ff <= rsp_data_ready_in;
      end
   end

   assign stat.rsp_free      = !rsp_valid_ff || rsp_ready;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_write_addr     = rsp_write_addr_ff;
   assign rsp_erase_now      = rsp_erase_now_ff;
   assign rsp_erase_addr     = rsp_erase_addr_ff;
   assign rsp_dropped_oldest = rsp_dropped_ff;
   assign rsp_read_addr      = rsp_read_addr_ff;
   assign rsp_log_full       = rsp_log_full_ff;
   assign rsp_data_ready     = rsp_data_ready_ff;

endmodule

[src/frlpm_checker.sv]
// Port-level checks of the pointer manager, bound to the top level.
`timescale 1ns / 1ps
module frlpm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [frlpm_pkg::FUNC_W-1:0]    req_func,
   input logic                            req_write_ok,
   input logic [frlpm_pkg::FIELD_W-1:0]   req_new_read_addr,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [frlpm_pkg::FIELD_W-1:0]   rsp_write_addr,
   input logic                            rsp_erase_now,
   input logic [frlpm_pkg::FIELD_W-1:0]   rsp_erase_addr,
   input logic                            rsp_dropped_oldest,
   input logic [frlpm_pkg::FIELD_W-1:0]   rsp_read_addr,
   input logic                            rsp_log_full,
   input logic                            rsp_data_ready,
   input logic                            csr_we,
   input logic [frlpm_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [frlpm_pkg::CSR_W-1:0]     csr_wdata
);
   import frlpm_pkg::*;

   // A stalled response stays valid and holds its addresses and full flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_write_addr) &&
      $stable(rsp_read_addr) && $stable(rsp_erase_addr) && $stable(rsp_log_full))
      else $error("response changed while stalled");

   // No erase address without an erase
   a_erase_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_erase_now |-> rsp_erase_addr == '0)
      else $error("erase address without erase request");

   // A write outcome never erases or drops a record
   a_outcome_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data_ready |-> !rsp_erase_now && !rsp_dropped_oldest)
      else $error("outcome response carries prepare flags");

   // Nothing is reported right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind flash_ring_log_pointer_manager_core frlpm_checker u_frlpm_checker (.*);
